// ===== rtl/key_value_table_defines.svh =====
// Assertion macros shared by the key-value table RTL.
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Check prop at every rising clock edge, skipped while reset is low.
`define KVT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define KVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KVT_ASSERT(lbl, clk, rstn, prop, msg)
`define KVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/kvt_pkg.sv =====
// Types and constants of the key-value table.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic signed [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] value_out;
        logic               full_error;
        logic [6:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

endpackage

// ===== rtl/kvt_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  kvt_pkg::t_slot       i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output kvt_pkg::t_slot       o_rdata
);
    import kvt_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/key_value_table.sv =====
// Key-value table of TABLE_DEPTH slots: insert/update, lookup and remove by a scan over the slots.
// Each request walks every slot through one memory read port and one key comparator, one slot
// per cycle, tracking the first matching slot and the lowest free slot; a writeback state then
// updates the slot and the entry count and loads the result register. The block is ready again
// in the same cycle that the result appears. The next item is taken once the result is loaded,
// even while it waits on the output; a writeback waits while the previous result is still held.
// After reset a clearing pass marks every slot free; no item is accepted meanwhile. entry_count
// reports the low 7 bits of the count.
`timescale 1ns / 1ps
`include "key_value_table_defines.svh"

module key_value_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kvt_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output kvt_pkg::t_rsp  o_out_data
);
    import kvt_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_issue_done, n_issue_done;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_pend_idx, n_pend_idx;
    t_req            r_req, n_req;
    logic            r_hit, n_hit;
    logic [AW-1:0]   r_match_idx, n_match_idx;
    logic [31:0]     r_match_val, n_match_val;
    logic            r_free_found, n_free_found;
    logic [AW-1:0]   r_free_idx, n_free_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;
    t_rsp            r_out, n_out;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_slot           w_wdata;
    t_slot           w_rdata;
    logic [CW+6:0]   w_cnt_ext;

    kvt_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_issue_done <= n_issue_done;
        r_pend_idx   <= n_pend_idx;
        r_req        <= n_req;
        r_hit        <= n_hit;
        r_match_idx  <= n_match_idx;
        r_match_val  <= n_match_val;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_req        = r_req;
        n_hit        = r_hit;
        n_match_idx  = r_match_idx;
        n_match_val  = r_match_val;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_count      = r_count;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_cnt_ext    = {7'd0, r_count};

        case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_in_data;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read a cycle; data for r_pend_idx arrives in the following cycle
                if (!r_issue_done) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr;
                    n_addr     = r_addr + AW'(1);
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_pend) begin
                    if (w_rdata.vld && (w_rdata.key == r_req.key) && !r_hit) begin
                        n_hit       = 1'b1;
                        n_match_idx = r_pend_idx;
                        n_match_val = w_rdata.value;
                    end
                    if (!w_rdata.vld && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_pend_idx;
                    end
                    if (r_issue_done) begin
                        n_state = S_WB;
                    end
                end
            end
            S_WB: begin
                // hold until the previous result has left
                if (!r_out_valid || i_out_ready) begin
                    n_out.hit        = 1'b0;
                    n_out.value_out  = '0;
                    n_out.full_error = 1'b0;
                    case (r_req.req_type)
                        REQ_INSERT: begin
                            if (r_hit) begin
                                w_we            = 1'b1;
                                w_waddr         = r_match_idx;
                                w_wdata         = {1'b1, r_req.key, r_req.value_in};
                                n_out.hit       = 1'b1;
                                n_out.value_out = r_match_val;
                            end else if (r_free_found) begin
                                w_we    = 1'b1;
                                w_waddr = r_free_idx;
                                w_wdata = {1'b1, r_req.key, r_req.value_in};
                                n_count = r_count + CW'(1);
                            end else begin
                                n_out.full_error = 1'b1;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (r_hit) begin
                                n_out.hit       = 1'b1;
                                n_out.value_out = r_match_val;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_hit) begin
                                w_we            = 1'b1;
                                w_waddr         = r_match_idx;
                                n_out.hit       = 1'b1;
                                n_out.value_out = r_match_val;
                                n_count         = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    w_cnt_ext         = {7'd0, n_count};
                    n_out.entry_count = w_cnt_ext[6:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `KVT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH), "entry count above depth")
    `KVT_ASSERT(a_full_no_hit, i_clk, i_rst_n, o_out_valid |-> !(o_out_data.full_error && o_out_data.hit), "full_error with hit")
    `KVT_ASSERT(a_free_room, i_clk, i_rst_n, (r_state == S_WB && r_free_found) |-> (r_count < CW'(TABLE_DEPTH)), "free slot found in a full table")
    `KVT_ASSERT_ALWAYS(a_no_accept_in_clear, i_clk, (r_state == S_CLEAR) |-> !o_in_ready, "item taken during clearing pass")

endmodule

// ===== dv/key_value_table_checker.sv =====
// Channel monitor, table predictor and response comparator for the key-value table.
`timescale 1ns / 1ps

module key_value_table_checker #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  kvt_pkg::t_req i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  kvt_pkg::t_rsp i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import kvt_pkg::*;

    logic        slot_used [TABLE_DEPTH];
    logic [31:0] slot_key  [TABLE_DEPTH];
    logic [31:0] slot_val  [TABLE_DEPTH];
    int unsigned live_entries;
    t_rsp        rsp_due [$];
    int          fails = 0;

    // Apply one request to the shadow table and return the response it must produce.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   match_idx;
        int   free_idx;
        rsp       = '0;
        match_idx = -1;
        free_idx  = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (match_idx < 0 && slot_used[i] && slot_key[i] == req.key) begin
                match_idx = i;
            end
            if (free_idx < 0 && !slot_used[i]) begin
                free_idx = i;
            end
        end
        case (req.req_type)
            REQ_INSERT: begin
                if (match_idx >= 0) begin
                    rsp.hit             = 1'b1;
                    rsp.value_out       = slot_val[match_idx];
                    slot_val[match_idx] = req.value_in;
                end else if (free_idx < 0) begin
                    rsp.full_error = 1'b1;
                end else begin
                    slot_used[free_idx] = 1'b1;
                    slot_key[free_idx]  = req.key;
                    slot_val[free_idx]  = req.value_in;
                    live_entries++;
                end
            end
            REQ_LOOKUP: begin
                if (match_idx >= 0) begin
                    rsp.hit       = 1'b1;
                    rsp.value_out = slot_val[match_idx];
                end
            end
            REQ_REMOVE: begin
                if (match_idx >= 0) begin
                    rsp.hit              = 1'b1;
                    rsp.value_out        = slot_val[match_idx];
                    slot_used[match_idx] = 1'b0;
                    if (live_entries > 0) begin
                        live_entries--;
                    end
                end
            end
            default: begin
                // unused request code leaves the table alone
            end
        endcase
        rsp.entry_count = live_entries[6:0];
        return rsp;
    endfunction

    task automatic compare_rsp(input t_rsp got);
        t_rsp want;
        if (rsp_due.size() == 0) begin
            $error("response with no request outstanding: hit %0b value_out %0d full_error %0b entry_count %0d",
                   got.hit, got.value_out, got.full_error, got.entry_count);
            fails++;
        end else begin
            want = rsp_due.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                fails++;
            end
            if (got.value_out !== want.value_out) begin
                $error("value_out: expected %0d, actual %0d", want.value_out, got.value_out);
                fails++;
            end
            if (got.full_error !== want.full_error) begin
                $error("full_error: expected %0b, actual %0b", want.full_error, got.full_error);
                fails++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
            end
            live_entries = 0;
            rsp_due.delete();
        end else begin
            // retire the oldest response before queuing a new request
            if (i_out_valid && i_out_ready) begin
                compare_rsp(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                rsp_due.insert(rsp_due.size(), apply_request(i_in_data));
            end
        end
        o_pending    <= rsp_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_key_value_table.sv =====
// Stimulus, flow control and verdict for the key-value table testbench.
`timescale 1ns / 1ps

module tb_key_value_table;
    import kvt_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 64;
    localparam logic [1:0]  REQ_NOP      = 2'd3;
    localparam logic [31:0] S32_MIN      = 32'h8000_0000;
    localparam logic [31:0] S32_MAX      = 32'h7fff_ffff;
    localparam int          POOL_SIZE    = 80;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          IDLE_LIMIT   = 4000;

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_data;

    int          fail_count;
    int          pending;
    int          idle_pct      = 20;
    bit          hold_request  = 1'b0;
    int          quiet_cycles  = 0;
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] live_keys [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    key_value_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    key_value_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item, maybe after a gap, and hold it until the table takes it.
    task automatic send_req(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        t_req req;
        req.req_type = op;
        req.key      = k;
        req.value_in = v;
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_mixed(input int count, input int pool_used, input int ins_w,
                             input int look_w, input int rem_w);
        int          r;
        logic [1:0]  op;
        logic [31:0] k;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                op = REQ_INSERT;
            end else if (r < ins_w + look_w) begin
                op = REQ_LOOKUP;
            end else if (r < ins_w + look_w + rem_w) begin
                op = REQ_REMOVE;
            end else begin
                op = REQ_NOP;
            end
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom;
            end else begin
                k = key_pool[$urandom_range(0, pool_used - 1)];
            end
            send_req(op, k, $urandom);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("key_value_table verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          pick;
        logic [31:0] k;

        // pool keys: every fifth one sits a single bit away from its neighbor
        key_pool[0] = 32'd0;
        for (int i = 1; i < POOL_SIZE; i++) begin
            if (i % 5 == 1) begin
                key_pool[i] = key_pool[i - 1] ^ (32'd1 << $urandom_range(0, 31));
            end else begin
                key_pool[i] = $urandom;
            end
        end
        key_pool[2] = S32_MIN;
        key_pool[3] = S32_MAX;
        key_pool[4] = 32'hffff_ffff;

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // misses and no-op on an empty table, then inserts and lookups of edge keys
        send_req(REQ_LOOKUP, 32'd0, 32'd0);
        send_req(REQ_REMOVE, 32'd5, 32'hffff_ffff);
        send_req(REQ_NOP, 32'd0, 32'd0);
        send_req(REQ_INSERT, 32'd0, S32_MAX);
        send_req(REQ_INSERT, S32_MIN, S32_MIN);
        send_req(REQ_INSERT, S32_MAX, 32'hffff_ffff);
        send_req(REQ_INSERT, 32'hffff_ffff, 32'd0);
        send_req(REQ_LOOKUP, S32_MIN, 32'd0);
        send_req(REQ_LOOKUP, S32_MAX, 32'h5a5a_a5a5);
        // update returns the old value
        send_req(REQ_INSERT, 32'd0, S32_MIN);
        // keys one bit off a stored key must miss
        send_req(REQ_LOOKUP, 32'd1, 32'd0);
        send_req(REQ_LOOKUP, 32'h8000_0001, 32'd0);
        send_req(REQ_REMOVE, S32_MAX, 32'd0);
        send_req(REQ_REMOVE, S32_MAX, 32'd0);
        send_req(REQ_NOP, 32'd0, S32_MAX);
        send_req(REQ_LOOKUP, 32'd0, 32'd0);
        send_req(REQ_INSERT, 32'h7fff_fffe, 32'd5);
        send_req(REQ_INSERT, S32_MAX, 32'd7);
        send_req(REQ_REMOVE, 32'hffff_ffff, 32'd0);
        send_req(REQ_REMOVE, 32'd0, 32'd0);
        send_req(REQ_REMOVE, S32_MIN, 32'd0);
        send_req(REQ_REMOVE, 32'h7fff_fffe, 32'd0);
        send_req(REQ_REMOVE, S32_MAX, 32'd0);

        // fill every slot, overflow it, then drain
        idle_pct = 10;
        repeat (TABLE_DEPTH) begin
            k = $urandom;
            live_keys.insert(live_keys.size(), k);
            send_req(REQ_INSERT, k, $urandom);
        end
        repeat (4) send_req(REQ_INSERT, $urandom, $urandom);
        send_req(REQ_INSERT, live_keys[$urandom_range(0, live_keys.size() - 1)], $urandom);
        pick = $urandom_range(0, live_keys.size() - 1);
        send_req(REQ_REMOVE, live_keys[pick], $urandom);
        live_keys.delete(pick);
        k = $urandom;
        live_keys.insert(live_keys.size(), k);
        send_req(REQ_INSERT, k, $urandom);
        send_req(REQ_INSERT, $urandom, $urandom);
        repeat (6) send_req(REQ_LOOKUP, live_keys[$urandom_range(0, live_keys.size() - 1)],
                            $urandom);
        idle_pct = 30;
        while (live_keys.size() > 0) begin
            pick = $urandom_range(0, live_keys.size() - 1);
            k    = live_keys[pick];
            live_keys.delete(pick);
            send_req(REQ_REMOVE, k, $urandom);
            if ($urandom_range(0, 7) == 0) begin
                send_req(REQ_LOOKUP, k, $urandom);
            end
        end

        // keep offering while the output side holds off, so the input backs up
        idle_pct     = 25;
        hold_request = 1'b1;
        run_mixed(170, 16, 40, 30, 25);
        wait_drained();

        // insert-heavy traffic over more keys than slots, alternating calm stretches
        for (int chunk = 0; chunk < 4; chunk++) begin
            idle_pct = (chunk % 2 == 1) ? 30 : 0;
            run_mixed(40, POOL_SIZE, 60, 20, 17);
        end

        idle_pct = 0;
        run_mixed(50, 16, 40, 30, 25);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("key_value_table verification clean");
        end else begin
            $display("key_value_table verification failed");
        end
        $finish;
    end

endmodule
